// ----- sv/lzw_pkg.sv -----
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared constants and controller/datapath interface types for the LZW encoder.
// ----------------------------------------------------------------------------
`default_nettype none
package lzw_pkg;
    localparam int MaxCodes = 4096;
    localparam int CodeW    = 12;
    localparam int NfcW     = 13;
    localparam int SymW     = 8;
    localparam int WidW     = 4;
    localparam int RootW    = 8;

    localparam logic [1:0] EMIT_GROUP = 2'd0;
    localparam logic [1:0] EMIT_CLEAR = 2'd1;
    localparam logic [1:0] EMIT_END   = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       init_group;
        logic       take_head;
        logic       step;
        logic       hit;
        logic       emit;
        logic [1:0] emit_sel;
        logic       add1;
        logic       add2;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic started;
        logic last;
        logic child_zero;
        logic match;
        logic sib_zero;
        logic emit_ok;
        logic full;
    } t_stat;
endpackage
`default_nettype wire

// ----- sv/lzw_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// lzw_stream_encoder
// LZW encoder with variable code width, clear code and end code.
// ----------------------------------------------------------------------------
// One symbol is taken at a time. A symbol that extends the current group
// is accepted, fetches the head of the prefix's child chain and compares
// each sibling in it; a symbol that closes a group adds the emit and the two
// dictionary writes, and one more emit step per extra word (table full, end
// of stream). The rate is set by the single read port of the entry memory
// that the chain walk steps through. Codes leave through a one-word output
// register; a dictionary restart clears all root links together, so no
// clearing pass follows reset. Writing symbol_bits restarts the stream.
`default_nettype none
module lzw_stream_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_code,
    output logic [3:0]       o_code_width,
    output logic             o_last_code,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_symbol_bits
);
    import lzw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lzw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lzw_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_symbol_bits (i_cfg_symbol_bits),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_code            (o_code),
        .o_code_width      (o_code_width),
        .o_last_code       (o_last_code)
    );
endmodule
`default_nettype wire

// ----- sv/lzw_dpath.sv -----
// ----------------------------------------------------------------------------
// lzw_dpath
// Dictionary memories, group/code state and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lzw_pkg::t_cmd i_cmd,
    output lzw_pkg::t_stat     o_stat,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    input  wire logic          i_cfg_we,
    input  wire logic [3:0]    i_cfg_symbol_bits,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [11:0]        o_code,
    output logic [3:0]         o_code_width,
    output logic               o_last_code
);
    import lzw_pkg::*;

    logic [3:0]        r_sb;
    logic [SymW-1:0]   r_sym;
    logic              r_last;
    logic [CodeW-1:0]  r_group;
    logic              r_started;
    logic [NfcW-1:0]   r_nfc;
    logic [WidW-1:0]   r_cw;
    logic [CodeW-1:0]  r_head;
    logic [CodeW-1:0]  r_link;
    logic [(1<<RootW)-1:0] r_valid;
    logic [CodeW-1:0]  r_link_q;
    logic [SymW+CodeW-1:0] r_ent_q;
    logic              r_ovalid;
    logic [CodeW-1:0]  r_ocode;
    logic [WidW-1:0]   r_owidth;
    logic              r_olast;

    // first_child per code, and {symbol, next_sibling} per code
    logic [CodeW-1:0]      mem_link [MaxCodes];
    logic [SymW+CodeW-1:0] mem_ent  [MaxCodes];

    logic [3:0]       sbe;
    logic [CodeW-1:0] cc;
    logic [SymW-1:0]  sym_in;
    logic             root;
    logic [CodeW-1:0] head_rd;
    logic [SymW-1:0]  ent_sym;
    logic [CodeW-1:0] ent_sib;
    logic [CodeW-1:0] ent_raddr;
    logic [NfcW-1:0]  nfc_inc;
    logic [NfcW:0]    pow;
    logic             do_clear;
    logic             emit_ok;
    logic [CodeW-1:0] emit_code;

    always_comb begin
        if (r_sb < 4'd2) begin
            sbe = 4'd2;
        end else if (r_sb > 4'd8) begin
            sbe = 4'd8;
        end else begin
            sbe = r_sb;
        end
    end

    assign cc        = CodeW'(1) << sbe;
    assign sym_in    = i_data_byte & SymW'(cc - CodeW'(1));
    assign root      = (r_group[CodeW-1:RootW] == '0);
    assign head_rd   = (root && !r_valid[r_group[RootW-1:0]]) ? '0 : r_link_q;
    assign ent_sym   = r_ent_q[SymW+CodeW-1:CodeW];
    assign ent_sib   = r_ent_q[CodeW-1:0];
    assign ent_raddr = i_cmd.take_head ? head_rd : ent_sib;
    assign nfc_inc   = r_nfc + NfcW'(1);
    assign pow       = (NfcW+1)'(1) << r_cw;
    assign do_clear  = i_cmd.clear || i_cfg_we;
    assign emit_ok   = !r_ovalid || !i_stall;

    always_comb begin
        unique case (i_cmd.emit_sel)
            EMIT_CLEAR: emit_code = cc;
            EMIT_END:   emit_code = cc + CodeW'(1);
            default:    emit_code = r_group;
        endcase
    end

    // dictionary memories: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.add1) begin
            mem_ent[r_nfc[CodeW-1:0]]  <= {r_sym, r_head};
            mem_link[r_nfc[CodeW-1:0]] <= '0;
        end else if (i_cmd.add2) begin
            mem_link[r_group] <= r_nfc[CodeW-1:0];
        end
        r_link_q <= mem_link[r_group];
        r_ent_q  <= mem_ent[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb      <= 4'd8;
            r_started <= 1'b0;
            r_group   <= '0;
            r_valid   <= '0;
            r_nfc     <= NfcW'(258);
            r_cw      <= WidW'(9);
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sb <= i_cfg_symbol_bits;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.init_group) begin
                r_group   <= CodeW'(r_sym);
                r_started <= 1'b1;
            end
            if (i_cmd.hit) begin
                r_group <= r_link;
            end
            if (i_cmd.add1 && r_nfc[NfcW-1:RootW] == '0) begin
                r_valid[r_nfc[RootW-1:0]] <= 1'b1;
            end
            if (i_cmd.add2) begin
                if (root) begin
                    r_valid[r_group[RootW-1:0]] <= 1'b1;
                end
                r_nfc   <= nfc_inc;
                r_group <= CodeW'(r_sym);
                if ({1'b0, nfc_inc} == pow) begin
                    r_cw <= r_cw + WidW'(1);
                end
            end
            if (do_clear) begin
                r_valid   <= '0;
                r_started <= 1'b0;
                r_group   <= '0;
                // dictionary restart uses the new width when a write lands
                if (i_cfg_we) begin
                    r_nfc <= (NfcW'(1) << ((i_cfg_symbol_bits < 4'd2) ? 4'd2 :
                             (i_cfg_symbol_bits > 4'd8) ? 4'd8 : i_cfg_symbol_bits))
                             + NfcW'(2);
                    r_cw  <= ((i_cfg_symbol_bits < 4'd2) ? 4'd2 :
                             (i_cfg_symbol_bits > 4'd8) ? 4'd8 : i_cfg_symbol_bits)
                             + 4'd1;
                end else begin
                    r_nfc <= NfcW'(cc) + NfcW'(2);
                    r_cw  <= sbe + 4'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sym  <= sym_in;
            r_last <= i_last_byte;
        end
        if (i_cmd.take_head) begin
            r_head <= head_rd;
            r_link <= head_rd;
        end
        if (i_cmd.step) begin
            r_link <= ent_sib;
        end
        if (i_cmd.emit) begin
            r_ocode  <= emit_code;
            r_owidth <= r_cw;
            r_olast  <= (i_cmd.emit_sel == EMIT_END);
        end
    end

    assign o_stat.started    = r_started;
    assign o_stat.last       = r_last;
    assign o_stat.child_zero = (head_rd == '0);
    assign o_stat.match      = (ent_sym == r_sym);
    assign o_stat.sib_zero   = (ent_sib == '0);
    assign o_stat.emit_ok    = emit_ok;
    assign o_stat.full       = (r_nfc == NfcW'(MaxCodes - 1));

    assign o_valid      = r_ovalid;
    assign o_code       = r_ocode;
    assign o_code_width = r_owidth;
    assign o_last_code  = r_olast;
endmodule
`default_nettype wire

// ----- sv/lzw_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzw_ctrl
// Sequencer: accept, chain walk, entry insert, and code emission per symbol.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    output logic                o_cfg_ready,
    input  wire lzw_pkg::t_stat i_stat,
    output lzw_pkg::t_cmd       o_cmd
);
    import lzw_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_MISS  = 4'd3;
    localparam logic [3:0] S_ADD1  = 4'd4;
    localparam logic [3:0] S_ADD2  = 4'd5;
    localparam logic [3:0] S_FULL1 = 4'd6;
    localparam logic [3:0] S_FULL2 = 4'd7;
    localparam logic [3:0] S_LASTG = 4'd8;
    localparam logic [3:0] S_END   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_START;
                end
            end
            S_START: begin
                if (!i_stat.started) begin
                    o_cmd.init_group = 1'b1;
                    n_state = i_stat.last ? S_LASTG : S_IDLE;
                end else begin
                    o_cmd.take_head = 1'b1;
                    n_state = i_stat.child_zero ? S_MISS : S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = i_stat.last ? S_LASTG : S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = i_stat.sib_zero ? S_MISS : S_CMP;
                end
            end
            S_MISS: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_GROUP;
                    n_state        = S_ADD1;
                end
            end
            S_ADD1: begin
                o_cmd.add1 = 1'b1;
                n_state    = S_ADD2;
            end
            S_ADD2: begin
                o_cmd.add2 = 1'b1;
                if (i_stat.full) begin
                    n_state = S_FULL1;
                end else begin
                    n_state = i_stat.last ? S_LASTG : S_IDLE;
                end
            end
            S_FULL1: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_GROUP;
                    n_state        = S_FULL2;
                end
            end
            S_FULL2: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_CLEAR;
                    o_cmd.clear    = 1'b1;
                    n_state        = i_stat.last ? S_END : S_IDLE;
                end
            end
            S_LASTG: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_GROUP;
                    n_state        = S_END;
                end
            end
            S_END: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_END;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire
